[rtl/hsv2rgb_pkg.sv]
`timescale 1ns / 1ps

package hsv2rgb_pkg;

   // Field widths.
   localparam int HUE_W  = 15;
   localparam int CHAN_W = 8;
   localparam int FR_W   = 12;

   // Width of the q and t numerators, v * (255 * 3840 - s * fraction).
   localparam int NUM_W  = 28;

   // Hue scaling: 64 units per degree, 60 degrees per sector.
   localparam logic [HUE_W-1:0] HUE_SECTOR_UNITS = 15'd3840;
   localparam logic [HUE_W-1:0] HUE_FULL_UNITS   = 15'd23040;

   // Full scale of saturation and brightness.
   localparam logic [CHAN_W-1:0] UNIT_ONE = 8'd255;

   // Divisor of the q and t terms (255 * 3840), half of it for rounding,
   // and the reciprocal floor(2^40 / 979200) used to divide by it.
   localparam logic [19:0] BIG_DIV      = 20'd979200;
   localparam logic [19:0] BIG_HALF     = 20'd489600;
   localparam logic [20:0] BIG_RECIP    = 21'd1122867;
   localparam int          BIG_SHIFT    = 40;

   // Division of the p term by 255: ceil(2^23 / 255), and half of 255.
   localparam logic [15:0] P_RECIP      = 16'd32897;
   localparam int          P_SHIFT      = 23;
   localparam logic [6:0]  P_HALF       = 7'd127;

   // Hue sectors, 60 degrees each.
   localparam logic [2:0] SECTOR_RED_YELLOW    = 3'd0;
   localparam logic [2:0] SECTOR_YELLOW_GREEN  = 3'd1;
   localparam logic [2:0] SECTOR_GREEN_CYAN    = 3'd2;
   localparam logic [2:0] SECTOR_CYAN_BLUE     = 3'd3;
   localparam logic [2:0] SECTOR_BLUE_MAGENTA  = 3'd4;
   localparam logic [2:0] SECTOR_MAGENTA_RED   = 3'd5;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] brightness;
   } hsv_pixel_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_pixel_type;

endpackage

[rtl/hsv2rgb_round_div.sv]
`timescale 1ns / 1ps

// Two-stage rounded division of a numerator by 255 * 3840.
// The first stage multiplies by a reciprocal that never overestimates,
// so the estimate is exact or one too small; the second stage fixes it.
module hsv2rgb_round_div (
   input  logic                             clock,
   input  logic [hsv2rgb_pkg::NUM_W-1:0]    num,
   output logic [hsv2rgb_pkg::CHAN_W-1:0]   quot
);
   import hsv2rgb_pkg::*;

   localparam int PROD_W = NUM_W + 21;

   logic [NUM_W-1:0]  x_in;
   logic [PROD_W-1:0] prod;
   logic [NUM_W-1:0]  x_ff;
   logic [CHAN_W-1:0] est_ff;
   logic [NUM_W-1:0]  est_scaled;
   logic [NUM_W-1:0]  rem;
   logic [CHAN_W-1:0] quot_in;
   logic [CHAN_W-1:0] quot_ff;

   // Add half the divisor for round-to-nearest, then scale by the reciprocal.
   assign x_in = num + NUM_W'(BIG_HALF);
   assign prod = PROD_W'(x_in) * PROD_W'(BIG_RECIP);

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      est_ff <= prod[BIG_SHIFT+CHAN_W-1:BIG_SHIFT];
   end

   // The remainder is at most twice the divisor; one compare corrects it.
   assign est_scaled = NUM_W'(est_ff) * NUM_W'(BIG_DIV);
   assign rem        = x_ff - est_scaled;
   assign quot_in    = (rem >= NUM_W'(BIG_DIV)) ? est_ff + 8'd1 : est_ff;

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

[rtl/hsv_to_rgb_converter_top.sv]
`timescale 1ns / 1ps

// HSV to RGB converter. One pixel is taken on every clock in which start is
// high; busy never rises, and the receiver cannot stall. The RGB result
// comes out on rsp_pixel with rsp_valid high for one cycle, in input order,
// once it has passed the six-stage pipeline: sector split, the s products,
// the v products, and a two-stage reciprocal divide by 255 * 3840 with
// correction, then the channel select.
module hsv_to_rgb_converter_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  hsv2rgb_pkg::hsv_pixel_type  req_pixel,
   output logic                        rsp_valid,
   output hsv2rgb_pkg::rgb_pixel_type  rsp_pixel
);
   import hsv2rgb_pkg::*;

   localparam int VP_W   = 2 * CHAN_W;
   localparam int SF_W   = CHAN_W + FR_W;
   localparam int PP_W   = VP_W + 1 + 16;

   logic              accept;

   // Stage 1: clamp and sector split.
   logic [HUE_W-1:0]  hue_c;
   logic [2:0]        sector_in;
   logic [HUE_W-1:0]  base_in;
   logic [HUE_W-1:0]  fr_full;
   logic              s1_valid_ff;
   logic [2:0]        s1_sector_ff;
   logic [FR_W-1:0]   s1_fr_ff;
   logic [CHAN_W-1:0] s1_sat_ff;
   logic [CHAN_W-1:0] s1_val_ff;

   // Stage 2: products with saturation.
   logic              s2_valid_ff;
   logic [2:0]        s2_sector_ff;
   logic [CHAN_W-1:0] s2_val_ff;
   logic [VP_W-1:0]   s2_vp_ff;
   logic [SF_W-1:0]   s2_sf_ff;
   logic [SF_W-1:0]   s2_sg_ff;

   // Stage 3: products with brightness.
   logic              s3_valid_ff;
   logic [2:0]        s3_sector_ff;
   logic [CHAN_W-1:0] s3_val_ff;
   logic [PP_W-1:0]   s3_pprod_ff;
   logic [NUM_W-1:0]  s3_numq_ff;
   logic [NUM_W-1:0]  s3_numt_ff;

   // Stages 4 and 5: divide q and t, carry p alongside.
   logic              s4_valid_ff;
   logic [2:0]        s4_sector_ff;
   logic [CHAN_W-1:0] s4_val_ff;
   logic [CHAN_W-1:0] s4_p_ff;
   logic              s5_valid_ff;
   logic [2:0]        s5_sector_ff;
   logic [CHAN_W-1:0] s5_val_ff;
   logic [CHAN_W-1:0] s5_p_ff;
   logic [CHAN_W-1:0] q_chan;
   logic [CHAN_W-1:0] t_chan;

   // Stage 6: channel order.
   rgb_pixel_type     rsp_in;
   rgb_pixel_type     rsp_pixel_ff;
   logic              rsp_valid_ff;

   // The pipeline takes a pixel in every cycle.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Saturate the hue and find its sector by comparing to the boundaries.
   // A hue of a full turn folds back onto the start of the first sector.
   always_comb begin
      hue_c = (req_pixel.hue > HUE_FULL_UNITS) ? HUE_FULL_UNITS : req_pixel.hue;
      if (hue_c >= HUE_FULL_UNITS) begin
         sector_in = SECTOR_RED_YELLOW;
         base_in   = hue_c;
      end else if (hue_c >= 15'd19200) begin
         sector_in = SECTOR_MAGENTA_RED;
         base_in   = 15'd19200;
      end else if (hue_c >= 15'd15360) begin
         sector_in = SECTOR_BLUE_MAGENTA;
         base_in   = 15'd15360;
      end else if (hue_c >= 15'd11520) begin
         sector_in = SECTOR_CYAN_BLUE;
         base_in   = 15'd11520;
      end else if (hue_c >= 15'd7680) begin
         sector_in = SECTOR_GREEN_CYAN;
         base_in   = 15'd7680;
      end else if (hue_c >= HUE_SECTOR_UNITS) begin
         sector_in = SECTOR_YELLOW_GREEN;
         base_in   = HUE_SECTOR_UNITS;
      end else begin
         sector_in = SECTOR_RED_YELLOW;
         base_in   = 15'd0;
      end
      fr_full = hue_c - base_in;
   end

   // Valid bits travel with the data; payload registers need no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   // Stage 1 register.
   always_ff @(posedge clock) begin
      s1_sector_ff <= sector_in;
      s1_fr_ff     <= fr_full[FR_W-1:0];
      s1_sat_ff    <= req_pixel.saturation;
      s1_val_ff    <= req_pixel.brightness;
   end

   // Stage 2: v(1-s) numerator, s*f and s*(1-f).
   always_ff @(posedge clock) begin
      s2_sector_ff <= s1_sector_ff;
      s2_val_ff    <= s1_val_ff;
      s2_vp_ff     <= VP_W'(s1_val_ff) * VP_W'(UNIT_ONE - s1_sat_ff);
      s2_sf_ff     <= SF_W'(s1_sat_ff) * SF_W'(s1_fr_ff);
      s2_sg_ff     <= SF_W'(s1_sat_ff) * SF_W'(HUE_SECTOR_UNITS[FR_W-1:0] - s1_fr_ff);
   end

   // Stage 3: scale by v for q and t, and the reciprocal product for p.
   always_ff @(posedge clock) begin
      s3_sector_ff <= s2_sector_ff;
      s3_val_ff    <= s2_val_ff;
      s3_pprod_ff  <= PP_W'(VP_W'(s2_vp_ff) + VP_W'(P_HALF)) * PP_W'(P_RECIP);
      s3_numq_ff   <= NUM_W'(s2_val_ff) * NUM_W'(BIG_DIV - s2_sf_ff);
      s3_numt_ff   <= NUM_W'(s2_val_ff) * NUM_W'(BIG_DIV - s2_sg_ff);
   end

   // q and t each go through their own instance of the rounded divider.
   hsv2rgb_round_div u_div_q (
      .clock (clock),
      .num   (s3_numq_ff),
      .quot  (q_chan)
   );

   hsv2rgb_round_div u_div_t (
      .clock (clock),
      .num   (s3_numt_ff),
      .quot  (t_chan)
   );

   // Stages 4 and 5 keep the rest of the pixel in step with the divider.
   always_ff @(posedge clock) begin
      s4_sector_ff <= s3_sector_ff;
      s4_val_ff    <= s3_val_ff;
      s4_p_ff      <= s3_pprod_ff[P_SHIFT+CHAN_W-1:P_SHIFT];
      s5_sector_ff <= s4_sector_ff;
      s5_val_ff    <= s4_val_ff;
      s5_p_ff      <= s4_p_ff;
   end

   // The sector picks which channel gets v, p, q or t.
   always_comb begin
      case (s5_sector_ff)
         SECTOR_RED_YELLOW: begin
            rsp_in = '{red: s5_val_ff, green: t_chan, blue: s5_p_ff};
         end
         SECTOR_YELLOW_GREEN: begin
            rsp_in = '{red: q_chan, green: s5_val_ff, blue: s5_p_ff};
         end
         SECTOR_GREEN_CYAN: begin
            rsp_in = '{red: s5_p_ff, green: s5_val_ff, blue: t_chan};
         end
         SECTOR_CYAN_BLUE: begin
            rsp_in = '{red: s5_p_ff, green: q_chan, blue: s5_val_ff};
         end
         SECTOR_BLUE_MAGENTA: begin
            rsp_in = '{red: t_chan, green: s5_p_ff, blue: s5_val_ff};
         end
         default: begin
            rsp_in = '{red: s5_val_ff, green: s5_p_ff, blue: q_chan};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;

   // Every result comes from a matching transfer in.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 6))
      else $error("result without a matching transfer six cycles earlier");

   // Zero saturation gives a grey pixel at the input brightness.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_pixel.saturation, 6) == 8'd0) |->
         (rsp_pixel.red == $past(req_pixel.brightness, 6) &&
          rsp_pixel.green == rsp_pixel.red && rsp_pixel.blue == rsp_pixel.red))
      else $error("zero saturation did not give grey");

   // One channel always carries the brightness itself.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pixel.red == $past(req_pixel.brightness, 6) ||
                     rsp_pixel.green == $past(req_pixel.brightness, 6) ||
                     rsp_pixel.blue == $past(req_pixel.brightness, 6)))
      else $error("no channel equals the input brightness");

endmodule
